// File: rtl/core/stcb_pkg.sv
// ----------------------------------------------------------------------------
// stcb_pkg
// Shared types and constants for the stall-compensated time base.
// ----------------------------------------------------------------------------
`default_nettype none

package stcb_pkg;

    localparam int unsigned TIME_W = 64;
    localparam int unsigned THR_W  = 32;

    localparam logic [THR_W-1:0] THRESHOLD_RESET = 32'd100000000;

    typedef struct packed {
        logic [TIME_W-1:0] sys_time;
        logic [TIME_W-1:0] src_time;
    } item_t;

    typedef struct packed {
        logic [TIME_W-1:0] time_value;
        logic              non_monotonic;
        logic              stalled;
    } result_t;

    // handshake between the input register and the core
    typedef struct packed {
        logic valid;
        logic take;
    } stage_hs_t;

endpackage

`default_nettype wire

// File: rtl/core/stall_compensated_time_base.sv
// ----------------------------------------------------------------------------
// stall_compensated_time_base
// Compensated time from a wrapped source that may stall or step back.
// ----------------------------------------------------------------------------
//  channel  | handshake               | payload
//  ---------+-------------------------+-------------------------------------
//  input    | in_valid / in_stall     | sys_time, src_time
//  output   | out_valid / out_stall   | time_value, non_monotonic, stalled
//  config   | cfg_wr_en               | cfg_wr_data (stall threshold, ns)
//
//  one query per cycle while out_stall stays low; a query passes through the
//  input register, then the result register. offset state updates when a query
//  moves from the input register to the result register; that loop sets the rate
//  reset: threshold 100000000 ns, all offsets and history zero
//  a held result stops the core; the input register holds one more query,
//  then in_stall rises
// ----------------------------------------------------------------------------
`default_nettype none

module stall_compensated_time_base (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [63:0] sys_time,
    input  wire logic [63:0] src_time,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [63:0]      time_value,
    output logic             non_monotonic,
    output logic             stalled,
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data
);

    logic [stcb_pkg::THR_W-1:0] thr_reg;
    stcb_pkg::item_t            in_item;
    stcb_pkg::item_t            s1_item;
    logic                       s1_valid;
    stcb_pkg::stage_hs_t        hs;
    stcb_pkg::result_t          result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= stcb_pkg::THRESHOLD_RESET;
        end
        else if (cfg_wr_en)
        begin
            thr_reg <= cfg_wr_data;
        end
    end

    assign in_item = '{sys_time: sys_time, src_time: src_time};

    stcb_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .take     (hs.take),
        .s1_valid (s1_valid),
        .s1_item  (s1_item)
    );

    stcb_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .threshold (thr_reg),
        .s1_item   (s1_item),
        .hs        (hs),
        .s1_valid  (s1_valid),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .result    (result)
    );

    assign time_value    = result.time_value;
    assign non_monotonic = result.non_monotonic;
    assign stalled       = result.stalled;

endmodule

`default_nettype wire

// File: rtl/core/stcb_in_stage.sv
// ----------------------------------------------------------------------------
// stcb_in_stage
// Input register: holds one query until the core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module stcb_in_stage (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire stcb_pkg::item_t in_item,
    input  wire logic            take,
    output logic                 s1_valid,
    output stcb_pkg::item_t      s1_item
);

    logic            valid_reg;
    logic            valid_next;
    stcb_pkg::item_t item_reg;
    logic            load;

    assign in_stall = valid_reg && !take;
    assign load     = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= in_item;
        end
    end

    assign s1_valid = valid_reg;
    assign s1_item  = item_reg;

endmodule

`default_nettype wire

// File: rtl/core/stcb_core.sv
// ----------------------------------------------------------------------------
// stcb_core
// Offset state, per-query compensation and the result register.
// Keeps ro+so, ro+pw+so and ro+pw-pst so each output value needs at most one add.
// ----------------------------------------------------------------------------
`default_nettype none

module stcb_core (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [stcb_pkg::THR_W-1:0]  threshold,
    input  wire stcb_pkg::item_t             s1_item,
    output stcb_pkg::stage_hs_t              hs,
    input  wire logic                        s1_valid,
    input  wire logic                        out_stall,
    output logic                             out_valid,
    output stcb_pkg::result_t                result
);

    localparam int unsigned W = stcb_pkg::TIME_W;

    // sum terms: a = ro+so, c = ro+pw+so, d = ro+pw-pst
    logic [W-1:0] a_reg, a_next;
    logic [W-1:0] c_reg, c_next;
    logic [W-1:0] d_reg, d_next;
    logic [W-1:0] pw_reg;
    logic         pw_valid_reg;
    logic [W-1:0] pst_reg, pst_next;
    logic [W-1:0] po_reg;
    logic         po_valid_reg;
    logic         out_valid_reg;
    stcb_pkg::result_t result_reg;

    logic [W-1:0] sys;
    logic [W-1:0] wr;
    logic [W-1:0] gap;
    logic         exceeds;
    logic         stalled_c;
    logic [W-1:0] value;
    logic         nonmono;
    logic         take;

    assign sys = s1_item.sys_time;
    assign wr  = s1_item.src_time;

    assign take = s1_valid && (!out_valid_reg || !out_stall);
    assign hs   = '{valid: s1_valid, take: take};

    assign stalled_c = pw_valid_reg && (wr <= pw_reg);
    assign gap       = sys - pst_reg;
    assign exceeds   = !gap[W-1] && (gap > {{(W-stcb_pkg::THR_W){1'b0}}, threshold});

    always_comb
    begin
        a_next   = a_reg;
        d_next   = d_reg;
        pst_next = pst_reg;
        priority if (stalled_c && exceeds)
        begin
            value  = d_reg + sys;
            a_next = d_reg + sys - wr;
        end
        else if (stalled_c)
        begin
            value  = c_reg;
            a_next = c_reg - wr;
        end
        else
        begin
            value    = wr + a_reg;
            d_next   = a_reg + wr - sys;
            pst_next = sys;
        end
        c_next  = value;
        nonmono = po_valid_reg && (value < po_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg         <= '0;
            c_reg         <= '0;
            d_reg         <= '0;
            pw_reg        <= '0;
            pw_valid_reg  <= 1'b0;
            pst_reg       <= '0;
            po_reg        <= '0;
            po_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                a_reg        <= a_next;
                c_reg        <= c_next;
                d_reg        <= d_next;
                pw_reg       <= wr;
                pw_valid_reg <= 1'b1;
                pst_reg      <= pst_next;
                if (!nonmono)
                begin
                    po_reg       <= value;
                    po_valid_reg <= 1'b1;
                end
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            result_reg.time_value    <= value;
            result_reg.non_monotonic <= nonmono;
            result_reg.stalled       <= stalled_c;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

`default_nettype wire

// File: rtl/core/stcb_checker.sv
// ----------------------------------------------------------------------------
// stcb_checker
// Port-level checks for the stall-compensated time base.
// ----------------------------------------------------------------------------
`default_nettype none

module stcb_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [63:0] time_value,
    input wire logic        non_monotonic,
    input wire logic        stalled
);

    logic [63:0] last_reg;
    logic        have_reg;
    logic        out_xfer;

    assign out_xfer = out_valid && !out_stall;

    // last output that was not flagged
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg <= '0;
            have_reg <= 1'b0;
        end
        else if (out_xfer && !non_monotonic)
        begin
            last_reg <= time_value;
            have_reg <= 1'b1;
        end
    end

    a_held_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(time_value)
            && $stable(non_monotonic) && $stable(stalled))
        else $error("held result changed");

    a_accept_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !out_valid |-> !in_stall)
        else $error("input stalled with empty output");

    a_flag_means_drop: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && non_monotonic |-> have_reg && (time_value < last_reg))
        else $error("non_monotonic set without a drop");

    a_no_flag_means_rise: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && !non_monotonic && have_reg |-> time_value >= last_reg)
        else $error("drop in time not flagged");

    a_first_not_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && !have_reg |-> !stalled && !non_monotonic)
        else $error("first result marked stalled or flagged");

endmodule

bind stall_compensated_time_base stcb_checker u_stcb_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .time_value    (time_value),
    .non_monotonic (non_monotonic),
    .stalled       (stalled)
);

`default_nettype wire

// File: test/tb_stall_compensated_time_base.sv
// ----------------------------------------------------------------------------
// tb_stall_compensated_time_base
// Self-checking bench for the stall-compensated time base. A directed run
// goes first: the first query, the edges of the stall threshold, backward
// steps, system time going back, all-ones values and wrap-around. After it
// come random walks of system and wrapped time under several thresholds.
// A predictor inside the bench tracks the offsets and the output history.
// Every result is compared field by field, in order, with its prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_stall_compensated_time_base;

    localparam int unsigned STUCK_LIMIT  = 2000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned IDLE_PCT     = 22;
    localparam int unsigned BURST_LO     = 200;
    localparam int unsigned BURST_HI     = 280;
    localparam int unsigned HOLD_AT      = 350;
    localparam int unsigned HOLD_LEN     = 64;
    localparam int unsigned WALK_LEN     = 95;
    localparam int unsigned TW           = stcb_pkg::TIME_W;
    localparam int unsigned HW           = stcb_pkg::THR_W;

    typedef enum logic {OP_QUERY, OP_CFG} op_t;

    typedef struct packed {
        op_t           op;
        logic [TW-1:0] sys;
        logic [TW-1:0] wr;
        logic [HW-1:0] thr;
        logic          drain;
    } step_t;

    logic          clk           = 1'b0;
    logic          rst_n         = 1'b0;
    logic          in_valid      = 1'b0;
    logic          in_stall;
    logic [TW-1:0] sys_time      = '0;
    logic [TW-1:0] src_time      = '0;
    logic          out_valid;
    logic          out_stall     = 1'b0;
    logic [TW-1:0] time_value;
    logic          non_monotonic;
    logic          stalled;
    logic          cfg_wr_en     = 1'b0;
    logic [HW-1:0] cfg_wr_data   = '0;

    step_t             step_q[$];
    stcb_pkg::result_t expected_q[$];
    int unsigned       errors    = 0;
    int unsigned       n_in      = 0;
    int unsigned       stuck     = 0;
    int unsigned       hold_left = 0;
    logic              hold_done = 1'b0;
    logic              in_fire   = 1'b0;

    // predictor state
    logic [HW-1:0] thr_model   = stcb_pkg::THRESHOLD_RESET;
    logic [TW-1:0] last_wr     = '0;
    logic          have_wr     = 1'b0;
    logic [TW-1:0] progress_ts = '0;
    logic [TW-1:0] run_ofs     = '0;
    logic [TW-1:0] stall_ofs   = '0;
    logic [TW-1:0] last_out    = '0;
    logic          have_out    = 1'b0;

    // stimulus generator state
    logic [TW-1:0] gen_sys = '0;
    logic [TW-1:0] gen_wr  = '0;
    logic [HW-1:0] gen_thr = stcb_pkg::THRESHOLD_RESET;

    wire no_idle = (n_in >= BURST_LO) && (n_in < BURST_HI);

    stall_compensated_time_base dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .sys_time      (sys_time),
        .src_time      (src_time),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .time_value    (time_value),
        .non_monotonic (non_monotonic),
        .stalled       (stalled),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic stcb_pkg::result_t next_compensated(logic [TW-1:0] sys,
                                                           logic [TW-1:0] wr);
        stcb_pkg::result_t r;
        logic [TW-1:0]     gap;
        logic              no_progress;
        no_progress = have_wr && (wr <= last_wr);
        if (no_progress)
        begin
            gap = sys - progress_ts;
            // negative gap never counts as a stall
            if (!gap[TW-1] && gap > {32'd0, thr_model})
                stall_ofs = gap;
            run_ofs = run_ofs + (last_wr - wr);
        end
        else
        begin
            progress_ts = sys;
            run_ofs     = run_ofs + stall_ofs;
            stall_ofs   = '0;
        end
        last_wr = wr;
        have_wr = 1'b1;
        r.time_value    = wr + run_ofs + stall_ofs;
        r.non_monotonic = have_out && (r.time_value < last_out);
        r.stalled       = no_progress;
        if (!r.non_monotonic)
        begin
            last_out = r.time_value;
            have_out = 1'b1;
        end
        return r;
    endfunction

    task automatic push_query(logic [TW-1:0] sys, logic [TW-1:0] wr, logic drain);
        step_t st;
        st.op    = OP_QUERY;
        st.sys   = sys;
        st.wr    = wr;
        st.thr   = '0;
        st.drain = drain;
        step_q.push_back(st);
    endtask

    task automatic push_cfg(logic [HW-1:0] thr);
        step_t st;
        st.op    = OP_CFG;
        st.sys   = '0;
        st.wr    = '0;
        st.thr   = thr;
        st.drain = 1'b1;
        step_q.push_back(st);
        gen_thr = thr;
    endtask

    task automatic add_walk(int unsigned count);
        logic [TW-1:0] jump;
        int unsigned   pick;
        for (int unsigned i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 3))
                0:       jump = 64'($urandom_range(0, 255));
                1:       jump = {32'd0, gen_thr} + 64'($urandom_range(0, 6)) - 64'd3;
                2:       jump = 64'($urandom);
                default: jump = 64'($urandom_range(0, 2000000));
            endcase
            pick = $urandom_range(0, 99);
            if (pick < 48)
            begin
                gen_sys = gen_sys + jump;
                gen_wr  = gen_wr + 64'($urandom_range(1, 1000));
            end
            else if (pick < 70)
                gen_sys = gen_sys + jump;
            else if (pick < 82)
            begin
                gen_sys = gen_sys + jump;
                gen_wr  = gen_wr - 64'($urandom_range(1, 1000));
            end
            else if (pick < 90)
                gen_sys = gen_sys - jump;
            else if (pick < 95)
                gen_wr = gen_wr + jump;
            else
            begin
                // noise
                gen_sys = {$urandom, $urandom};
                gen_wr  = {$urandom, $urandom};
            end
            push_query(gen_sys, gen_wr, $urandom_range(0, 99) < 2);
        end
    endtask

    // input driver
    always @(negedge clk)
    begin
        logic          v;
        logic          en;
        logic [TW-1:0] s;
        logic [TW-1:0] w;
        logic [HW-1:0] d;
        step_t         nxt;
        v  = in_valid;
        en = 1'b0;
        s  = sys_time;
        w  = src_time;
        d  = cfg_wr_data;
        if (rst_n && (!in_valid || in_fire))
        begin
            v = 1'b0;
            if (step_q.size() != 0)
            begin
                nxt = step_q[0];
                if (nxt.drain && expected_q.size() != 0)
                    v = 1'b0;
                else if (nxt.op == OP_CFG)
                begin
                    nxt = step_q.pop_front();
                    en  = 1'b1;
                    d   = nxt.thr;
                end
                else if (no_idle || hold_left != 0 || $urandom_range(0, 99) >= IDLE_PCT)
                begin
                    nxt = step_q.pop_front();
                    v   = 1'b1;
                    s   = nxt.sys;
                    w   = nxt.wr;
                end
            end
        end
        in_valid    <= v;
        sys_time    <= s;
        src_time    <= w;
        cfg_wr_en   <= en;
        cfg_wr_data <= d;
    end

    // result receiver
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (n_in >= HOLD_AT && !hold_done)
        begin
            // long hold-off so the block backs up into in_stall
            out_stall <= 1'b1;
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end
        else
            out_stall <= !no_idle && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // monitor and predictor
    always @(posedge clk)
    begin
        stcb_pkg::result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("unexpected result transfer: time_value %h", time_value);
                    errors++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (time_value !== want.time_value)
                    begin
                        $error("time_value: expected %h, actual %h",
                               want.time_value, time_value);
                        errors++;
                    end
                    if (non_monotonic !== want.non_monotonic)
                    begin
                        $error("non_monotonic: expected %b, actual %b",
                               want.non_monotonic, non_monotonic);
                        errors++;
                    end
                    if (stalled !== want.stalled)
                    begin
                        $error("stalled: expected %b, actual %b", want.stalled, stalled);
                        errors++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                expected_q.push_back(next_compensated(sys_time, src_time));
                n_in <= n_in + 1;
            end
            if (cfg_wr_en)
                thr_model = cfg_wr_data;
            in_fire <= in_valid && !in_stall;
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
                stuck <= 0;
            else
                stuck <= stuck + 1;
        end
    end

    // watchdog
    initial
    begin
        while (stuck < STUCK_LIMIT)
            @(posedge clk);
        $display("status: fail");
        $finish;
    end

    initial
    begin
        // directed, reset threshold
        push_query(64'd0, 64'd0, 1'b0);
        push_query(64'd10, 64'd0, 1'b0);
        push_query({32'd0, stcb_pkg::THRESHOLD_RESET}, 64'd0, 1'b0);
        push_query({32'd0, stcb_pkg::THRESHOLD_RESET} + 64'd1, 64'd0, 1'b0);
        push_query({32'd0, stcb_pkg::THRESHOLD_RESET} + 64'd2, 64'd5, 1'b0);
        push_query({32'd0, stcb_pkg::THRESHOLD_RESET} + 64'd3, 64'd3, 1'b0);
        push_query(64'd400000000, 64'd3, 1'b0);
        push_query(64'd300000000, 64'd3, 1'b0);
        push_query(64'd5, 64'd3, 1'b0);
        push_query(64'd6, 64'd100, 1'b0);
        push_query('1, '1, 1'b0);
        push_query('1, 64'd0, 1'b0);
        push_query(64'd0, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
        push_query(64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
        push_query(64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
        push_cfg(32'd0);
        push_query(64'd1, 64'd1, 1'b0);
        push_query(64'd1, 64'h8000_0000_0000_0001, 1'b0);
        push_query(64'd1, 64'h8000_0000_0000_0001, 1'b0);
        push_cfg(32'hFFFF_FFFF);
        push_query(64'h1_0000_0000, 64'h8000_0000_0000_0001, 1'b0);
        push_query(64'h1_0000_0001, 64'h8000_0000_0000_0001, 1'b0);
        push_query(64'h1_0000_0002, 64'h8000_0000_0000_0002, 1'b0);

        // random walks
        gen_sys = 64'h1_0000_0002;
        gen_wr  = 64'h8000_0000_0000_0002;
        push_cfg(32'd0);
        add_walk(WALK_LEN);
        push_cfg(32'd1000);
        add_walk(WALK_LEN);
        push_cfg(32'hFFFF_FFFF);
        add_walk(WALK_LEN);
        gen_sys = 64'hFFFF_FFFF_F000_0000;
        gen_wr  = 64'hFFFF_FFFF_FFFF_0000;
        push_cfg(stcb_pkg::THRESHOLD_RESET);
        add_walk(WALK_LEN);
        push_cfg($urandom);
        add_walk(WALK_LEN);
        push_cfg(32'd1);
        add_walk(WALK_LEN);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (step_q.size() != 0 || in_valid || expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
